[sv/first_fit_heap_allocator_defines.svh]
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_defines
// Assertion macros shared by the allocator RTL.
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_HEAP_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_DEFINES_SVH

// same-cycle implication, disabled in reset
`define FFHA_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define FFHA_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/ffha_pkg.sv]
// ----------------------------------------------------------------------------
// ffha_pkg
// Operation and status codes, header type and helpers for the allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package ffha_pkg;

  typedef logic [15:0] hdr_t;
  typedef logic [1:0]  op_t;
  typedef logic [1:0]  status_t;

  localparam op_t OP_ALLOC  = 2'd0;
  localparam op_t OP_FREE   = 2'd1;
  localparam op_t OP_QUERY  = 2'd2;
  localparam op_t OP_FORMAT = 2'd3;

  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_NOFIT = 2'd1;
  localparam status_t ST_SMALL = 2'd2;

  localparam int WORD_BYTES       = 8;
  localparam int HEADER_MAX       = 32767;
  localparam int POOL_BYTES_RESET = 8192;

  function automatic logic hdr_pos(hdr_t v);
    return !v[15] && (v != 16'd0);
  endfunction

  function automatic logic [12:0] mag_words(hdr_t v);
    hdr_t a;
    a = v[15] ? (~v + 16'd1) : v;
    return a[15:3];
  endfunction

endpackage

`default_nettype wire

[sv/first_fit_heap_allocator.sv]
// ----------------------------------------------------------------------------
// first_fit_heap_allocator
// First-fit pool allocator with lazy coalescing, headers kept in one memory.
// ----------------------------------------------------------------------------
// Takes one word at a time and returns one result word for every op. Alloc
// and the largest-free query walk the header chain in the heap memory: each
// header is read and decoded, a free block first merges the following free
// blocks into itself while the sum fits a header, and the walk ends in a
// finish step (after a split step when an alloc splits a block). Free marks
// the used block at the offset as free, and ignores an offset of zero or one
// past the pool. Format clears the memory one word a cycle, or reports that
// the pool is too small. After reset the same clearing pass runs before the
// first word is taken. The heap memory has a single read and a single write port.
// ----------------------------------------------------------------------------
`default_nettype none

`include "first_fit_heap_allocator_defines.svh"

module first_fit_heap_allocator #(
  parameter int POOL_WORDS = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_op,
  input  wire logic [15:0] in_request_bytes,
  input  wire logic [12:0] in_free_offset,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_status,
  output logic [12:0]      out_address,
  output logic [13:0]      out_largest,
  input  wire logic        cfg_wr_en,
  input  wire logic [13:0] cfg_wr_data
);

  localparam int AW = (POOL_WORDS > 1) ? $clog2(POOL_WORDS) : 1;
  localparam int CW = $clog2(POOL_WORDS + 4097);
  localparam logic [CW-1:0] PW_C = CW'(POOL_WORDS);
  localparam logic [AW-1:0] LAST_A = AW'(POOL_WORDS - 1);
  localparam int MEM_BYTES = ffha_pkg::WORD_BYTES * POOL_WORDS;
  localparam logic [13:0] CAP14 = 14'((MEM_BYTES > 16383) ? 16383 : MEM_BYTES);
  localparam int RST_BYTES = (MEM_BYTES < ffha_pkg::POOL_BYTES_RESET) ?
                             MEM_BYTES : ffha_pkg::POOL_BYTES_RESET;
  localparam logic [15:0] RST_SIZE = 16'((RST_BYTES / 8) * 8 - 16);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_CLR  = 4'd1;
  localparam logic [3:0] S_RDH  = 4'd2;
  localparam logic [3:0] S_HDR  = 4'd3;
  localparam logic [3:0] S_ADV  = 4'd4;
  localparam logic [3:0] S_NXT  = 4'd5;
  localparam logic [3:0] S_DEC  = 4'd6;
  localparam logic [3:0] S_SPL  = 4'd7;
  localparam logic [3:0] S_FREE = 4'd8;
  localparam logic [3:0] S_FIN  = 4'd9;

  logic [3:0]          state_r, state_nxt;
  logic [CW-1:0]       idx_r, idx_nxt;
  logic [CW-1:0]       nidx_r, nidx_nxt;
  ffha_pkg::hdr_t      cur_r, cur_nxt;
  ffha_pkg::hdr_t      best_r, best_nxt;
  logic [16:0]         req_r, req_nxt;
  ffha_pkg::op_t       op_r, op_nxt;
  ffha_pkg::hdr_t      fmt_size_r, fmt_size_nxt;
  logic [AW-1:0]       clr_cnt_r, clr_cnt_nxt;
  logic                clr_rep_r, clr_rep_nxt;
  ffha_pkg::status_t   res_status_r, res_status_nxt;
  logic [12:0]         res_address_r, res_address_nxt;
  logic [13:0]         res_largest_r, res_largest_nxt;
  logic                out_valid_r, out_valid_nxt;
  ffha_pkg::status_t   out_status_r, out_status_nxt;
  logic [12:0]         out_address_r, out_address_nxt;
  logic [13:0]         out_largest_r, out_largest_nxt;
  logic [13:0]         pool_bytes_r, pool_bytes_nxt;

  ffha_pkg::hdr_t      heap_mem [POOL_WORDS];
  ffha_pkg::hdr_t      rd_data_r;
  logic [AW-1:0]       rd_addr;
  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  ffha_pkg::hdr_t      wr_data;

  logic [CW-1:0]       adv_idx;
  logic [CW-1:0]       spl_idx;
  logic [CW-1:0]       pay_idx;
  ffha_pkg::hdr_t      hdr_v;
  ffha_pkg::hdr_t      nxt_v;
  logic [16:0]         mrg_sum;
  ffha_pkg::hdr_t      rest;
  logic [13:0]         fmt_bytes;
  logic [9:0]          free_idx;
  logic                out_free;

  function automatic logic hdr_fits(logic [CW-1:0] i, ffha_pkg::hdr_t v);
    return (i + CW'(1) + CW'(ffha_pkg::mag_words(v))) < PW_C;
  endfunction

  assign adv_idx  = idx_r + CW'(1) + CW'(ffha_pkg::mag_words(cur_r));
  assign spl_idx  = idx_r + CW'(1) + CW'(req_r[16:3]);
  assign pay_idx  = idx_r + CW'(1);
  assign hdr_v    = hdr_fits(idx_r, rd_data_r) ? rd_data_r : 16'd0;
  assign nxt_v    = hdr_fits(nidx_r, rd_data_r) ? rd_data_r : 16'd0;
  assign mrg_sum  = {1'b0, cur_r} + {1'b0, nxt_v} + 17'(ffha_pkg::WORD_BYTES);
  assign rest     = cur_r - req_r[15:0];
  assign fmt_bytes = (pool_bytes_r > CAP14) ? CAP14 : pool_bytes_r;
  assign free_idx = in_free_offset[12:3] - 10'd1;
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt       = state_r;
    idx_nxt         = idx_r;
    nidx_nxt        = nidx_r;
    cur_nxt         = cur_r;
    best_nxt        = best_r;
    req_nxt         = req_r;
    op_nxt          = op_r;
    fmt_size_nxt    = fmt_size_r;
    clr_cnt_nxt     = clr_cnt_r;
    clr_rep_nxt     = clr_rep_r;
    res_status_nxt  = res_status_r;
    res_address_nxt = res_address_r;
    res_largest_nxt = res_largest_r;
    out_valid_nxt   = out_valid_r && out_stall;
    out_status_nxt  = out_status_r;
    out_address_nxt = out_address_r;
    out_largest_nxt = out_largest_r;
    pool_bytes_nxt  = cfg_wr_en ? cfg_wr_data : pool_bytes_r;
    rd_addr         = idx_r[AW-1:0];
    wr_en           = 1'b0;
    wr_addr         = idx_r[AW-1:0];
    wr_data         = 16'd0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt          = in_op;
          res_status_nxt  = ffha_pkg::ST_OK;
          res_address_nxt = 13'd0;
          res_largest_nxt = 14'd0;
          idx_nxt         = '0;
          best_nxt        = 16'd0;
          req_nxt         = ({1'b0, in_request_bytes} + 17'd7) & ~17'd7;
          if (req_nxt == 17'd0) begin
            req_nxt = 17'(ffha_pkg::WORD_BYTES);
          end
          unique case (in_op) inside
            ffha_pkg::OP_ALLOC, ffha_pkg::OP_QUERY: begin
              state_nxt = S_RDH;
            end
            ffha_pkg::OP_FREE: begin
              idx_nxt = CW'(free_idx);
              rd_addr = AW'(free_idx);
              if (in_free_offset[12:3] != 10'd0 && 32'(free_idx) < POOL_WORDS) begin
                state_nxt = S_FREE;
              end else begin
                state_nxt = S_FIN;
              end
            end
            ffha_pkg::OP_FORMAT: begin
              if (fmt_bytes <= 14'd16) begin
                res_status_nxt = ffha_pkg::ST_SMALL;
                state_nxt      = S_FIN;
              end else begin
                fmt_size_nxt = {2'b00, fmt_bytes[13:3], 3'b000} - 16'd16;
                clr_cnt_nxt  = '0;
                clr_rep_nxt  = 1'b1;
                state_nxt    = S_CLR;
              end
            end
            default: state_nxt = S_FIN;
          endcase
        end
      end
      S_CLR: begin
        wr_en   = 1'b1;
        wr_addr = clr_cnt_r;
        wr_data = (clr_cnt_r == '0) ? fmt_size_r : 16'd0;
        if (clr_cnt_r == LAST_A) begin
          state_nxt = clr_rep_r ? S_FIN : S_IDLE;
        end else begin
          clr_cnt_nxt = clr_cnt_r + AW'(1);
        end
      end
      S_RDH: begin
        rd_addr   = idx_r[AW-1:0];
        state_nxt = S_HDR;
      end
      S_HDR: begin
        cur_nxt   = hdr_v;
        state_nxt = ffha_pkg::hdr_pos(hdr_v) ? S_ADV : S_DEC;
      end
      S_ADV: begin
        nidx_nxt  = adv_idx;
        rd_addr   = adv_idx[AW-1:0];
        state_nxt = S_NXT;
      end
      S_NXT: begin
        if (ffha_pkg::hdr_pos(nxt_v) && mrg_sum <= 17'(ffha_pkg::HEADER_MAX)) begin
          wr_en     = 1'b1;
          wr_addr   = idx_r[AW-1:0];
          wr_data   = mrg_sum[15:0];
          cur_nxt   = mrg_sum[15:0];
          state_nxt = S_ADV;
        end else begin
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        if (cur_r == 16'd0) begin
          if (op_r == ffha_pkg::OP_ALLOC) begin
            res_status_nxt = ffha_pkg::ST_NOFIT;
          end else begin
            res_largest_nxt = best_r[13:0];
          end
          state_nxt = S_FIN;
        end else if (op_r == ffha_pkg::OP_ALLOC && !cur_r[15] &&
                     {2'b00, cur_r[14:0]} >= req_r) begin
          wr_en           = 1'b1;
          wr_addr         = idx_r[AW-1:0];
          res_address_nxt = {pay_idx[9:0], 3'b000};
          if (rest > 16'(ffha_pkg::WORD_BYTES)) begin
            wr_data   = ~req_r[15:0] + 16'd1;
            state_nxt = S_SPL;
          end else begin
            wr_data   = ~cur_r + 16'd1;
            state_nxt = S_FIN;
          end
        end else begin
          if (!cur_r[15] && cur_r > best_r) begin
            best_nxt = cur_r;
          end
          idx_nxt   = adv_idx;
          state_nxt = S_RDH;
        end
      end
      S_SPL: begin
        wr_en     = 1'b1;
        wr_addr   = spl_idx[AW-1:0];
        wr_data   = rest - 16'(ffha_pkg::WORD_BYTES);
        state_nxt = S_FIN;
      end
      S_FREE: begin
        if (rd_data_r[15] && rd_data_r != 16'h8000) begin
          wr_en   = 1'b1;
          wr_addr = idx_r[AW-1:0];
          wr_data = ~rd_data_r + 16'd1;
        end
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_status_nxt  = res_status_r;
          out_address_nxt = res_address_r;
          out_largest_nxt = res_largest_r;
          state_nxt       = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      heap_mem[wr_addr] <= wr_data;
    end
    rd_data_r <= heap_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLR;
      out_valid_r  <= 1'b0;
      pool_bytes_r <= 14'(ffha_pkg::POOL_BYTES_RESET);
      fmt_size_r   <= RST_SIZE;
      clr_cnt_r    <= '0;
      clr_rep_r    <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_valid_r  <= out_valid_nxt;
      pool_bytes_r <= pool_bytes_nxt;
      fmt_size_r   <= fmt_size_nxt;
      clr_cnt_r    <= clr_cnt_nxt;
      clr_rep_r    <= clr_rep_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r         <= idx_nxt;
    nidx_r        <= nidx_nxt;
    cur_r         <= cur_nxt;
    best_r        <= best_nxt;
    req_r         <= req_nxt;
    op_r          <= op_nxt;
    res_status_r  <= res_status_nxt;
    res_address_r <= res_address_nxt;
    res_largest_r <= res_largest_nxt;
    out_status_r  <= out_status_nxt;
    out_address_r <= out_address_nxt;
    out_largest_r <= out_largest_nxt;
  end

  assign in_stall    = (state_r != S_IDLE);
  assign out_valid   = out_valid_r;
  assign out_status  = out_status_r;
  assign out_address = out_address_r;
  assign out_largest = out_largest_r;

  `FFHA_ASSERT_NOW(a_adv_in_pool, state_r == S_ADV, adv_idx < PW_C,
    "next header index runs past the pool")
  `FFHA_ASSERT_NOW(a_split_after_dec, state_r == S_SPL, $past(state_r) == S_DEC,
    "split entered without a fit decision")
  `FFHA_ASSERT_NOW(a_result_from_fin, $rose(out_valid_r), $past(state_r) == S_FIN,
    "result word raised outside finish")
  `FFHA_ASSERT_NEXT(a_accept_leaves_idle, in_valid && !in_stall, state_r != S_IDLE,
    "accepted word did not start work")

endmodule

`default_nettype wire
